/* src/binary_morphology_3x3_2d_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 binary morphology unit
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_3X3_2D_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_2D_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define BM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked on every edge, reset included.
`define BM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BM_ASSERT(name, clk, rstn, prop, msg)
`define BM_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* src/binmorph_pkg.sv */
// ----------------------------------------------------------------------------
// Binary morphology package
// Field widths, configuration register indexes and shared types.
// ----------------------------------------------------------------------------
package binmorph_pkg;

    localparam int PIX_W      = 16;  // pixel field width on the ports
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LW_W       = 11;  // line_width register
    localparam int FH_W       = 16;  // frame_height register
    localparam int ROW_W      = FH_W + 1;  // row counter reaches height + 1

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLY_BG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ROI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd6;

    // mode register values
    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // which window borders lie inside the image for the centre pixel
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_ok_t;

endpackage

/* src/binmorph_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module binmorph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];  // read-before-write on same address
        end
    end

endmodule

/* src/binary_morphology_3x3_2d_unit.sv */
// ----------------------------------------------------------------------------
// 3x3 binary morphology unit
// One dilation or conditional erosion pass over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  input    | s_valid / s_ready   | s_action, s_pixel, s_roi_flag
//  result   | m_valid / m_ready   | m_result_pixel, m_frame_last
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One input transaction per clock when the result side keeps up; the
//  transaction completing a window goes through the A->B register, then
//  the result register. The line RAM (one read and one write per pixel)
//  sets that rate. After reset a clearing pass zeroes the line RAM, one
//  entry per cycle; s_ready stays low meanwhile. cfg_ready is always high.
//  While m_valid is held by a low m_ready the whole pipe holds.
//
// Pipeline:
//   A  position counters, border flags, line RAM read issued
//   B  line RAM data (with same-address forwarding), RAM write-back,
//      window shift and 3x3 evaluation into the result register
// ----------------------------------------------------------------------------
`include "binary_morphology_3x3_2d_unit_defines.svh"

module binary_morphology_3x3_2d_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input pixel stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [binmorph_pkg::PIX_W-1:0]      s_pixel,
    input  logic                                s_roi_flag,
    // result stream
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [binmorph_pkg::PIX_W-1:0]      m_result_pixel,
    output logic                                m_frame_last,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [binmorph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [binmorph_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);      // column / RAM address
    localparam int WW    = $clog2(MAX_WIDTH + 1);  // holds the width itself
    localparam int MW    = 2 * PIXEL_BITS + 1;     // {two lines back, one back, roi}
    localparam int ROW_W = binmorph_pkg::ROW_W;
    localparam int PW    = binmorph_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                            mode_reg;
    logic                            only_bg_reg;
    logic                            use_roi_reg;
    logic [PW-1:0]                   match_reg;
    logic [PW-1:0]                   source_reg;
    logic [binmorph_pkg::LW_W-1:0]   lw_reg;
    logic [binmorph_pkg::FH_W-1:0]   fh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= binmorph_pkg::MODE_DILATE;
            only_bg_reg <= 1'b0;
            use_roi_reg <= 1'b0;
            match_reg   <= PW'(1);
            source_reg  <= '0;
            lw_reg      <= binmorph_pkg::LW_W'(1024);
            fh_reg      <= binmorph_pkg::FH_W'(1024);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                binmorph_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                binmorph_pkg::CFG_ONLY_BG: only_bg_reg <= cfg_data[0];
                binmorph_pkg::CFG_USE_ROI: use_roi_reg <= cfg_data[0];
                binmorph_pkg::CFG_MATCH:   match_reg   <= cfg_data;
                binmorph_pkg::CFG_SOURCE:  source_reg  <= cfg_data;
                binmorph_pkg::CFG_WIDTH:   lw_reg      <= cfg_data[binmorph_pkg::LW_W-1:0];
                binmorph_pkg::CFG_HEIGHT:  fh_reg      <= cfg_data[binmorph_pkg::FH_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Effective geometry: width clamped to 1..MAX_WIDTH, height to at least 1.
    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    wm1;
    logic [PW-1:0]    h_eff;
    logic [ROW_W-1:0] h_ext;
    logic [ROW_W-1:0] hm1;
    logic [ROW_W-1:0] hp1;

    always_comb begin
        if (lw_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(lw_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(lw_reg);
        end
        h_eff = (fh_reg == '0) ? PW'(1) : fh_reg;
    end

    assign wm1   = w_eff - WW'(1);
    assign h_ext = ROW_W'(h_eff);
    assign hm1   = h_ext - ROW_W'(1);
    assign hp1   = h_ext + ROW_W'(1);

    // ------------------------------------------------------------------
    // Line RAM clearing pass after reset
    // ------------------------------------------------------------------
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(MAX_WIDTH - 1)) begin
                clr_busy_next = 1'b0;
                clr_addr_next = '0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: everything moves when the result register is free
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    logic adv;
    logic accept;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv && !clr_busy_reg;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage A: raster position
    // ------------------------------------------------------------------
    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    x_a;
    logic [ROW_W-1:0] y_a;
    logic             drain_a;
    logic             skip_a;      // flush before frame end: no effect
    logic             emit_a;
    logic             last_a;
    logic [WW-1:0]    x_inc;
    logic [AW-1:0]    cx_a;
    logic [ROW_W-1:0] cy_a;
    binmorph_pkg::nbr_ok_t ok_a;
    logic [PIXEL_BITS-1:0] pix_a;

    // column past a shrunk width moves on; positions past the drain restart
    always_comb begin
        x_a = col_reg;
        y_a = row_reg;
        if (WW'(col_reg) >= w_eff) begin
            x_a = '0;
            y_a = row_reg + ROW_W'(1);
        end
        if (y_a > hp1 || (y_a == hp1 && x_a != '0)) begin
            x_a = '0;
            y_a = '0;
        end
    end

    assign drain_a = (y_a >= h_ext);
    assign skip_a  = s_action && !drain_a;
    assign emit_a  = (x_a != '0 && y_a != '0) || (y_a >= ROW_W'(2));
    assign x_inc   = WW'(x_a) + WW'(1);

    // centre pixel of the window is one column and one row behind
    assign cx_a = (x_a != '0) ? (x_a - AW'(1)) : AW'(wm1);
    assign cy_a = (x_a != '0) ? (y_a - ROW_W'(1)) : (y_a - ROW_W'(2));

    assign ok_a.top    = (cy_a != '0);
    assign ok_a.bottom = (cy_a < hm1);
    assign ok_a.left   = (cx_a != '0);
    assign ok_a.right  = (x_a != '0) && (WW'(cx_a) < wm1);
    assign last_a      = emit_a && (WW'(cx_a) == wm1) && (cy_a == hm1);

    assign pix_a = drain_a ? '0 : s_pixel[PIXEL_BITS-1:0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (skip_a) begin
                col_next = x_a;
                row_next = y_a;
            end else if (last_a) begin
                col_next = '0;
                row_next = '0;
            end else if (x_inc >= w_eff) begin
                col_next = '0;
                row_next = y_a + ROW_W'(1);
            end else begin
                col_next = AW'(x_inc);
                row_next = y_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A -> B register
    // ------------------------------------------------------------------
    logic                  load_a;
    logic                  s1_valid_reg, s1_valid_next;
    logic [AW-1:0]         s1_x_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_roi_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    binmorph_pkg::nbr_ok_t s1_ok_reg;
    logic                  byp_reg;
    logic [MW-1:0]         fwd_reg;
    logic [MW-1:0]         wr_word;

    assign load_a        = accept && !skip_a;
    assign s1_valid_next = adv ? load_a : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // The item leaving B writes the RAM in the cycle this one reads it;
    // on the same column its write data is forwarded instead.
    always_ff @(posedge aclk) begin
        if (load_a) begin
            s1_x_reg    <= x_a;
            s1_pix_reg  <= pix_a;
            s1_roi_reg  <= drain_a ? 1'b0 : s_roi_flag;
            s1_emit_reg <= emit_a;
            s1_last_reg <= last_a;
            s1_ok_reg   <= ok_a;
            byp_reg     <= s1_valid_reg && (s1_x_reg == x_a);
            fwd_reg     <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // Line RAM: {two lines back, one line back, delayed roi flag}
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic [MW-1:0] ram_rdata;
    logic          b_fire;

    assign b_fire    = s1_valid_reg && adv;
    assign ram_we    = clr_busy_reg || b_fire;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_x_reg;
    assign ram_wdata = clr_busy_reg ? '0 : wr_word;

    binmorph_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (load_a),
        .rd_addr (x_a),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage B: window shift and evaluation
    // ------------------------------------------------------------------
    logic [MW-1:0]         rd_word;
    logic [PIXEL_BITS-1:0] up2;
    logic [PIXEL_BITS-1:0] up1;
    logic                  roi_old;
    logic                  roi_hold_reg;   // flag of the current centre pixel
    logic [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [PIXEL_BITS-1:0] win_next [3][3];
    logic                  row_ok [3];
    logic                  col_ok [3];
    logic [PW-1:0]         target;
    logic [PW-1:0]         centre;
    logic                  hit;
    logic                  bg;
    logic                  proc;
    logic [PW-1:0]         res;

    function automatic logic pix_eq(input logic [PIXEL_BITS-1:0] v,
                                    input logic [PW-1:0] t);
        pix_eq = (PW'(v) == t);
    endfunction

    assign rd_word = byp_reg ? fwd_reg : ram_rdata;
    assign up2     = rd_word[MW-1 -: PIXEL_BITS];
    assign up1     = rd_word[PIXEL_BITS -: PIXEL_BITS];
    assign roi_old = rd_word[0];
    assign wr_word = {up1, s1_pix_reg, s1_roi_reg};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up2;
        win_next[1][2] = up1;
        win_next[2][2] = s1_pix_reg;
    end

    assign row_ok[0] = s1_ok_reg.top;
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = s1_ok_reg.bottom;
    assign col_ok[0] = s1_ok_reg.left;
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = s1_ok_reg.right;

    assign target = (mode_reg == binmorph_pkg::MODE_DILATE) ? PW'(1) : source_reg;
    assign centre = PW'(win_next[1][1]);

    always_comb begin
        hit = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c] && pix_eq(win_next[r][c], target)) begin
                    hit = 1'b1;
                end
            end
        end
    end

    // background test over in-image 4-neighbours
    assign bg = (col_ok[0] && pix_eq(win_next[1][0], '0))
             || (col_ok[2] && pix_eq(win_next[1][2], '0))
             || (row_ok[0] && pix_eq(win_next[0][1], '0))
             || (row_ok[2] && pix_eq(win_next[2][1], '0));

    assign proc = (!use_roi_reg || roi_hold_reg) && (!only_bg_reg || bg);

    always_comb begin
        res = centre;
        if (proc) begin
            if (mode_reg == binmorph_pkg::MODE_DILATE) begin
                res = hit ? PW'(1) : '0;
            end else if (centre == match_reg && hit) begin
                res = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_hold_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (b_fire) begin
            roi_hold_reg <= roi_old;
            win_reg      <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [PW-1:0] res_reg;
    logic          last_reg;

    assign out_valid_next = adv ? (s1_valid_reg && s1_emit_reg) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && s1_emit_reg) begin
            res_reg  <= res;
            last_reg <= s1_last_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_pixel = res_reg;
    assign m_frame_last   = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BM_ASSERT(a_clear_quiet, aclk, aresetn, clr_busy_reg |-> !s_ready && !s1_valid_reg && !out_valid_reg, "pipe active during line RAM clear")
    `BM_ASSERT(a_clear_wrap, aclk, aresetn, $fell(clr_busy_reg) |-> clr_addr_reg == '0, "clear sweep ended off its last entry")
    `BM_ASSERT(a_stage_hold, aclk, aresetn, s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_x_reg), "stage B item lost while result stalled")

endmodule
